>>> design/idat_pkg.sv
// ----------------------------------------------------------------------------
// idat_pkg
// Request/response types and codes for the round-robin id allocator table.
// ----------------------------------------------------------------------------
package idat_pkg;

  // request kinds
  localparam logic [2:0] KIND_ALLOC   = 3'd0;
  localparam logic [2:0] KIND_INSERT  = 3'd1;
  localparam logic [2:0] KIND_REPLACE = 3'd2;
  localparam logic [2:0] KIND_LOOKUP  = 3'd3;
  localparam logic [2:0] KIND_REMOVE  = 3'd4;

  // response status codes
  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_IN_USE    = 3'd1;
  localparam logic [2:0] STATUS_BAD_ID    = 3'd2;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
  localparam logic [2:0] STATUS_FULL      = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  req_id;
    logic [31:0] payload;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  result_id;
    logic [31:0] read_data;
  } rsp_t;

endpackage

>>> design/idat_store.sv
// ----------------------------------------------------------------------------
// idat_store
// Entry memory of the id table: one valid bit plus data per id, one write
// and one registered read per cycle, swept to all zero after reset.
// ----------------------------------------------------------------------------
module idat_store #(
  parameter int ID_BITS   = 8,
  parameter int WORD_BITS = 33
) (
  input  logic                 clk,
  input  logic                 rst,
  output logic                 clear_busy,
  input  logic                 wr_en,
  input  logic [ID_BITS-1:0]   wr_addr,
  input  logic [WORD_BITS-1:0] wr_word,
  input  logic                 rd_en,
  input  logic [ID_BITS-1:0]   rd_addr,
  output logic [WORD_BITS-1:0] rd_word
);

  localparam int DEPTH = 1 << ID_BITS;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic                 clearing;
  logic [ID_BITS-1:0]   clr_addr;

  assign clear_busy = clearing;

  // clearing pass walks every entry once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

endmodule

>>> design/id_allocator_table_unit.sv
// ----------------------------------------------------------------------------
// id_allocator_table_unit
// Direct-indexed id table with round-robin allocation, insert, replace,
// lookup and remove.
// ----------------------------------------------------------------------------
// Each request reads its entry from the table memory through a registered
// read port and is decided from that word in the evaluate state; the result
// goes to the output register once that register is free. Allocate probes
// one candidate id per cycle through that same memory read port, starting
// at the rotating pointer, and probes 1 up to 2^ID_BITS-2 ids, the last
// case ending in a table full status. The block takes one request
// at a time; a finished result waits in the output register and a further
// result stalls only while that register is still held. After reset the
// table is cleared one entry per cycle before the first request is taken.
// ----------------------------------------------------------------------------
module id_allocator_table_unit #(
  parameter int ID_BITS   = 8,
  parameter int DATA_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  idat_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output idat_pkg::rsp_t   rsp
);

  localparam int WORD_BITS = DATA_BITS + 1;
  localparam logic [ID_BITS-1:0] END_ID    = ID_BITS'((1 << ID_BITS) - 1);
  localparam logic [ID_BITS-1:0] SWEEP_LEN = ID_BITS'((1 << ID_BITS) - 2);
  localparam logic [ID_BITS-1:0] FIRST_ID  = ID_BITS'(1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EVAL = 1'b1;

  logic                 state;
  logic [ID_BITS-1:0]   next_free;
  logic [2:0]           kind;
  logic [ID_BITS-1:0]   id;
  logic [DATA_BITS-1:0] data;
  logic [ID_BITS-1:0]   addr;
  logic [ID_BITS-1:0]   tries;

  logic                 clear_busy;
  logic                 rd_en;
  logic [ID_BITS-1:0]   rd_addr;
  logic [WORD_BITS-1:0] rd_word;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_word;

  logic                 accept;
  logic                 out_free;
  logic                 done;
  logic                 probe;
  logic                 vld;
  logic                 occ;
  logic                 fin;
  logic                 wr_req;
  logic [2:0]           st;
  logic [ID_BITS-1:0]   rid;
  logic [DATA_BITS-1:0] rdat;
  logic [ID_BITS-1:0]   ptr_inc;
  logic [ID_BITS-1:0]   ptr_adv;

  idat_store #(
    .ID_BITS   (ID_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .clear_busy (clear_busy),
    .wr_en      (wr_en),
    .wr_addr    (addr),
    .wr_word    (wr_word),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_word    (rd_word)
  );

  assign req_ready = (state == ST_IDLE) && !clear_busy;
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  // pointer runs over 1..END_ID-1 and wraps back to 1
  assign ptr_inc = next_free + 1'b1;
  assign ptr_adv = (ptr_inc == END_ID || ptr_inc == '0) ? FIRST_ID : ptr_inc;

  assign vld = rd_word[DATA_BITS];
  assign occ = vld && (rd_word[DATA_BITS-1:0] != '0);

  always_comb begin
    fin     = 1'b1;
    probe   = 1'b0;
    wr_req  = 1'b0;
    wr_word = {1'b1, data};
    st      = idat_pkg::STATUS_NOT_FOUND;
    rid     = '0;
    rdat    = '0;
    unique case (kind)
      idat_pkg::KIND_ALLOC: begin
        if (!occ) begin
          wr_req = 1'b1;
          st     = idat_pkg::STATUS_OK;
          rid    = addr;
        end else if (tries == SWEEP_LEN) begin
          st = idat_pkg::STATUS_FULL;
        end else begin
          fin   = 1'b0;
          probe = 1'b1;
        end
      end
      idat_pkg::KIND_INSERT: begin
        if (id == '0) begin
          st = idat_pkg::STATUS_BAD_ID;
        end else if (occ) begin
          st = idat_pkg::STATUS_IN_USE;
        end else begin
          wr_req = 1'b1;
          st     = idat_pkg::STATUS_OK;
          rid    = id;
        end
      end
      idat_pkg::KIND_REPLACE: begin
        if (id == '0) begin
          st = idat_pkg::STATUS_BAD_ID;
        end else begin
          wr_req = 1'b1;
          st     = idat_pkg::STATUS_OK;
          rid    = id;
        end
      end
      idat_pkg::KIND_LOOKUP: begin
        if (vld) begin
          st   = idat_pkg::STATUS_OK;
          rid  = id;
          rdat = rd_word[DATA_BITS-1:0];
        end
      end
      idat_pkg::KIND_REMOVE: begin
        if (vld) begin
          wr_req  = 1'b1;
          wr_word = {1'b0, rd_word[DATA_BITS-1:0]};
          st      = idat_pkg::STATUS_OK;
          rid     = id;
        end
      end
      default: begin
        st = idat_pkg::STATUS_NOT_FOUND;
      end
    endcase
  end

  assign done  = (state == ST_EVAL) && fin && out_free;
  assign wr_en = done && wr_req;
  assign rd_en = accept || ((state == ST_EVAL) && probe);

  always_comb begin
    if (state == ST_IDLE) begin
      rd_addr = (req.kind == idat_pkg::KIND_ALLOC) ? next_free : ID_BITS'(req.req_id);
    end else begin
      rd_addr = next_free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      next_free <= FIRST_ID;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        state <= ST_EVAL;
        if (req.kind == idat_pkg::KIND_ALLOC) begin
          next_free <= ptr_adv;
        end
      end else if ((state == ST_EVAL) && probe) begin
        next_free <= ptr_adv;
      end else if (done) begin
        state <= ST_IDLE;
      end
      if (done) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind  <= req.kind;
      id    <= ID_BITS'(req.req_id);
      data  <= DATA_BITS'(req.payload);
      addr  <= rd_addr;
      tries <= FIRST_ID;
    end else if ((state == ST_EVAL) && probe) begin
      addr  <= next_free;
      tries <= tries + 1'b1;
    end
    if (done) begin
      rsp.status    <= st;
      rsp.result_id <= 8'(rid);
      rsp.read_data <= 32'(rdat);
    end
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    next_free != '0 && next_free != END_ID)
    else $error("allocation pointer left its range");

  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_EVAL)
    else $error("transfer did not start evaluation");

  a_tries_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && kind == idat_pkg::KIND_ALLOC) |->
      (tries != '0 && tries <= SWEEP_LEN))
    else $error("allocation probe count out of range");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> addr != '0)
    else $error("write to id zero");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == idat_pkg::STATUS_FULL) |->
      (rsp.result_id == '0 && rsp.read_data == '0))
    else $error("table full result carries an id or data");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the round-robin id allocator table. A short table of
// directed requests runs first, then about a thousand random requests in
// phases that mix all kinds, fill the table with allocations, and drain
// it again. Each response is compared field by field with its typed
// directed-row expectation or else with the software table copy's prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 10;

  // request kinds that the block does not define
  localparam logic [2:0] KIND_RSVD_A = 3'd5;
  localparam logic [2:0] KIND_RSVD_B = 3'd6;
  localparam logic [2:0] KIND_RSVD_C = 3'd7;

  typedef enum int {PH_MIX, PH_FILL, PH_DRAIN} phase_t;

  typedef struct {
    idat_pkg::req_t item;
    bit             typed;
    idat_pkg::rsp_t rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  idat_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  idat_pkg::rsp_t rsp;

  // expectation typed into the directed table, travels with the request
  bit             row_typed = 1'b0;
  idat_pkg::rsp_t row_rsp = '0;

  id_allocator_table_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the table
  logic [7:0]  alloc_ptr = 8'd1;
  bit          id_present [256];
  logic [31:0] id_word [256];

  idat_pkg::rsp_t due_rsp_q [$];
  dir_row_t       dir_rows [$];
  logic [7:0]     recent_ids [16];
  logic [3:0]     recent_wr = '0;

  int n_sent = 0;
  int n_seen = 0;
  int n_errors = 0;
  int n_alloc = 0;
  int n_full = 0;
  int n_zero_store = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  function automatic bit id_taken(input logic [7:0] id);
    return id_present[id] && id_word[id] != '0;
  endfunction

  function automatic idat_pkg::rsp_t next_response(input idat_pkg::req_t r);
    idat_pkg::rsp_t o;
    logic [7:0]     cand;
    bit             done;
    int             n;
    o = '0;
    o.status = idat_pkg::STATUS_NOT_FOUND;
    done = 1'b0;
    case (r.kind)
      idat_pkg::KIND_ALLOC: begin
        o.status = idat_pkg::STATUS_FULL;
        for (n = 0; n < 254 && !done; n++) begin
          cand = alloc_ptr;
          alloc_ptr = alloc_ptr + 8'd1;
          if (alloc_ptr == 8'hff || alloc_ptr == 8'h00) alloc_ptr = 8'd1;
          if (!id_taken(cand)) begin
            id_present[cand] = 1'b1;
            id_word[cand] = r.payload;
            o.status = idat_pkg::STATUS_OK;
            o.result_id = cand;
            done = 1'b1;
          end
        end
      end
      idat_pkg::KIND_INSERT: begin
        if (r.req_id == 8'd0) begin
          o.status = idat_pkg::STATUS_BAD_ID;
        end else if (id_taken(r.req_id)) begin
          o.status = idat_pkg::STATUS_IN_USE;
        end else begin
          id_present[r.req_id] = 1'b1;
          id_word[r.req_id] = r.payload;
          o.status = idat_pkg::STATUS_OK;
          o.result_id = r.req_id;
        end
      end
      idat_pkg::KIND_REPLACE: begin
        if (r.req_id == 8'd0) begin
          o.status = idat_pkg::STATUS_BAD_ID;
        end else begin
          id_present[r.req_id] = 1'b1;
          id_word[r.req_id] = r.payload;
          o.status = idat_pkg::STATUS_OK;
          o.result_id = r.req_id;
        end
      end
      idat_pkg::KIND_LOOKUP: begin
        if (id_present[r.req_id]) begin
          o.status = idat_pkg::STATUS_OK;
          o.result_id = r.req_id;
          o.read_data = id_word[r.req_id];
        end
      end
      idat_pkg::KIND_REMOVE: begin
        if (id_present[r.req_id]) begin
          id_present[r.req_id] = 1'b0;
          o.status = idat_pkg::STATUS_OK;
          o.result_id = r.req_id;
        end
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  // response check and request capture
  always @(posedge clk) begin : monitor
    idat_pkg::rsp_t want;
    idat_pkg::rsp_t pred;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        n_seen++;
        if (due_rsp_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected response: expected none, actual %0d/%0d/%h", $time,
                   rsp.status, rsp.result_id, rsp.read_data);
        end else begin
          want = due_rsp_q.pop_front();
          if (rsp.status !== want.status) begin
            n_errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                     want.status, rsp.status);
          end
          if (rsp.result_id !== want.result_id) begin
            n_errors++;
            $display("%0t: result_id mismatch: expected %0d, actual %0d", $time,
                     want.result_id, rsp.result_id);
          end
          if (rsp.read_data !== want.read_data) begin
            n_errors++;
            $display("%0t: read_data mismatch: expected %h, actual %h", $time,
                     want.read_data, rsp.read_data);
          end
        end
      end
      if (req_valid && req_ready) begin
        pred = next_response(req);
        if (req.kind == idat_pkg::KIND_ALLOC) n_alloc++;
        if (pred.status == idat_pkg::STATUS_FULL) n_full++;
        if (req.kind <= idat_pkg::KIND_REPLACE && req.payload == '0 &&
            pred.status == idat_pkg::STATUS_OK)
          n_zero_store++;
        if (pred.status == idat_pkg::STATUS_OK && pred.result_id != 8'd0) begin
          recent_ids[recent_wr] = pred.result_id;
          recent_wr = recent_wr + 4'd1;
        end
        due_rsp_q.push_back(row_typed ? row_rsp : pred);
      end
      idle_cycles <= ((req_valid && req_ready) || (rsp_valid && rsp_ready)) ? 0 :
                     idle_cycles + 1;
    end
  end

  // receiver stall pattern, mode chosen anew at random whenever its run ends
  int       stall_left = 0;
  int       stall_mode = 0;
  logic [7:0] cyc = '0;

  always @(posedge clk) begin
    cyc <= cyc + 8'd1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: rsp_ready <= 1'b1;
      1: rsp_ready <= 1'($urandom_range(0, 1));
      2: rsp_ready <= (cyc % 3 == 0);
      default: rsp_ready <= (cyc[2:0] == 3'd7);
    endcase
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic add_row(input logic [2:0] kind, input logic [7:0] id,
                         input logic [31:0] payload, input bit typed,
                         input logic [2:0] status, input logic [7:0] rid,
                         input logic [31:0] rdata);
    dir_row_t row;
    row.item = '{kind: kind, req_id: id, payload: payload};
    row.typed = typed;
    row.rsp = '{status: status, result_id: rid, read_data: rdata};
    dir_rows.push_back(row);
  endtask

  task automatic drive_item(input idat_pkg::req_t item, input bit typed,
                            input idat_pkg::rsp_t typed_rsp);
    int gap;
    req <= item;
    req_valid <= 1'b1;
    row_typed <= typed;
    row_rsp <= typed_rsp;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold off new requests until every response is back
  task automatic wait_drained;
    req_valid <= 1'b0;
    @(posedge clk);
    while (n_seen < n_sent) @(posedge clk);
  endtask

  function automatic idat_pkg::req_t make_item(input phase_t ph);
    idat_pkg::req_t r;
    int             roll;
    roll = $urandom_range(0, 99);
    r.req_id = $urandom_range(0, 1) ? recent_ids[$urandom_range(0, 15)] :
               8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: r.payload = '0;
      1: r.payload = '1;
      default: r.payload = $urandom;
    endcase
    case (ph)
      PH_FILL: begin
        // keep data nonzero so every allocation really takes an id
        if (r.payload == '0) r.payload = $urandom | 32'd1;
        if (roll < 85) r.kind = idat_pkg::KIND_ALLOC;
        else if (roll < 93) r.kind = idat_pkg::KIND_LOOKUP;
        else r.kind = idat_pkg::KIND_INSERT;
      end
      PH_DRAIN: begin
        if (roll < 55) begin
          r.kind = idat_pkg::KIND_REMOVE;
          if ($urandom_range(0, 1)) r.req_id = 8'($urandom_range(1, 254));
        end else if (roll < 75) begin
          r.kind = idat_pkg::KIND_ALLOC;
        end else if (roll < 90) begin
          r.kind = idat_pkg::KIND_LOOKUP;
        end else begin
          r.kind = idat_pkg::KIND_REPLACE;
        end
      end
      default: begin
        if (roll < 25) r.kind = idat_pkg::KIND_ALLOC;
        else if (roll < 40) r.kind = idat_pkg::KIND_INSERT;
        else if (roll < 55) r.kind = idat_pkg::KIND_REPLACE;
        else if (roll < 75) r.kind = idat_pkg::KIND_LOOKUP;
        else if (roll < 95) r.kind = idat_pkg::KIND_REMOVE;
        else r.kind = 3'($urandom_range(KIND_RSVD_A, KIND_RSVD_C));
      end
    endcase
    return r;
  endfunction

  initial begin : stimulus
    phase_t plan [4];
    int     plan_len [4];
    int     p;
    int     k;
    for (k = 0; k < 16; k++) recent_ids[k] = 8'(k + 1);

    add_row(idat_pkg::KIND_LOOKUP, 8'd5, 32'h0,
            1, idat_pkg::STATUS_NOT_FOUND, 8'd0, 32'h0);
    add_row(idat_pkg::KIND_REMOVE, 8'd0, 32'h0,
            1, idat_pkg::STATUS_NOT_FOUND, 8'd0, 32'h0);
    add_row(idat_pkg::KIND_LOOKUP, 8'd0, 32'h0,
            1, idat_pkg::STATUS_NOT_FOUND, 8'd0, 32'h0);
    add_row(idat_pkg::KIND_INSERT, 8'd0, 32'h7,
            1, idat_pkg::STATUS_BAD_ID, 8'd0, 32'h0);
    add_row(idat_pkg::KIND_REPLACE, 8'd0, 32'hffffffff,
            1, idat_pkg::STATUS_BAD_ID, 8'd0, 32'h0);
    add_row(idat_pkg::KIND_ALLOC, 8'd0, 32'hffffffff,
            1, idat_pkg::STATUS_OK, 8'd1, 32'h0);
    add_row(idat_pkg::KIND_ALLOC, 8'd200, 32'h1,
            1, idat_pkg::STATUS_OK, 8'd2, 32'h0);
    add_row(idat_pkg::KIND_LOOKUP, 8'd1, 32'h0,
            1, idat_pkg::STATUS_OK, 8'd1, 32'hffffffff);
    add_row(idat_pkg::KIND_INSERT, 8'd1, 32'h5,
            1, idat_pkg::STATUS_IN_USE, 8'd0, 32'h0);
    add_row(idat_pkg::KIND_INSERT, 8'd255, 32'ha5a5a5a5,
            1, idat_pkg::STATUS_OK, 8'd255, 32'h0);
    add_row(idat_pkg::KIND_LOOKUP, 8'd255, 32'h0,
            1, idat_pkg::STATUS_OK, 8'd255, 32'ha5a5a5a5);
    // zero data: still present, but free for insert and allocate
    add_row(idat_pkg::KIND_REPLACE, 8'd255, 32'h0,
            1, idat_pkg::STATUS_OK, 8'd255, 32'h0);
    add_row(idat_pkg::KIND_LOOKUP, 8'd255, 32'h0,
            1, idat_pkg::STATUS_OK, 8'd255, 32'h0);
    add_row(idat_pkg::KIND_INSERT, 8'd255, 32'h5a5a5a5a,
            1, idat_pkg::STATUS_OK, 8'd255, 32'h0);
    add_row(idat_pkg::KIND_REMOVE, 8'd255, 32'h0,
            1, idat_pkg::STATUS_OK, 8'd255, 32'h0);
    add_row(idat_pkg::KIND_REMOVE, 8'd255, 32'h0,
            1, idat_pkg::STATUS_NOT_FOUND, 8'd0, 32'h0);
    add_row(idat_pkg::KIND_REPLACE, 8'd3, 32'h0,
            0, idat_pkg::STATUS_OK, 8'd0, 32'h0);
    add_row(idat_pkg::KIND_ALLOC, 8'd0, 32'h12345678,
            0, idat_pkg::STATUS_OK, 8'd0, 32'h0);
    add_row(idat_pkg::KIND_LOOKUP, 8'd3, 32'h0,
            0, idat_pkg::STATUS_OK, 8'd0, 32'h0);
    add_row(KIND_RSVD_A, 8'd3, 32'h0,
            1, idat_pkg::STATUS_NOT_FOUND, 8'd0, 32'h0);
    add_row(KIND_RSVD_B, 8'd255, 32'hffffffff,
            1, idat_pkg::STATUS_NOT_FOUND, 8'd0, 32'h0);
    add_row(KIND_RSVD_C, 8'd1, 32'h1,
            1, idat_pkg::STATUS_NOT_FOUND, 8'd0, 32'h0);
    add_row(idat_pkg::KIND_REMOVE, 8'd1, 32'h0,
            0, idat_pkg::STATUS_OK, 8'd0, 32'h0);
    add_row(idat_pkg::KIND_ALLOC, 8'd0, 32'h0,
            0, idat_pkg::STATUS_OK, 8'd0, 32'h0);
    add_row(idat_pkg::KIND_ALLOC, 8'd0, 32'hffffffff,
            0, idat_pkg::STATUS_OK, 8'd0, 32'h0);

    plan[0] = PH_MIX;   plan_len[0] = 280;
    plan[1] = PH_FILL;  plan_len[1] = 300;
    plan[2] = PH_DRAIN; plan_len[2] = 200;
    plan[3] = PH_MIX;   plan_len[3] = 250;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) drive_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].rsp);
    wait_drained();

    for (p = 0; p < 4; p++) begin
      for (k = 0; k < plan_len[p]; k++) drive_item(make_item(plan[p]), 1'b0, '0);
      if (plan[p] == PH_FILL) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_rsp_q.size() != 0) begin
      n_errors++;
      $display("%0t: %0d responses never arrived", $time, due_rsp_q.size());
    end

    $display("ran %0d requests: %0d allocations, %0d table-full answers, %0d zero-data stores",
             n_sent, n_alloc, n_full, n_zero_store);
    $display("%0d responses compared, %0d mismatches", n_seen, n_errors);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/idat_pkg.sv
design/idat_store.sv
design/id_allocator_table_unit.sv
tb/testbench.sv
